/* src/controller_led_animation_machine_top_defines.svh */
// assertion macros for the led animation machine checker
`ifndef CONTROLLER_LED_ANIMATION_MACHINE_TOP_DEFINES_SVH
`define CONTROLLER_LED_ANIMATION_MACHINE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CLAM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CLAM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/clam_pkg.sv */
// shared types, constants and functions of the led animation machine
package clam_pkg;

    localparam int ANIM_DEPTH      = 16;
    localparam int EXIT_DEPTH      = 64;
    localparam int STATE_DEPTH     = 16;
    localparam int EXIT_LIST_DEPTH = 64;
    localparam int NUM_LIGHTS      = 5;

    localparam int ANIM_AW  = $clog2(ANIM_DEPTH);
    localparam int EXIT_AW  = $clog2(EXIT_DEPTH);
    localparam int STATE_AW = $clog2(STATE_DEPTH);
    localparam int LIST_AW  = $clog2(EXIT_LIST_DEPTH);

    localparam logic [7:0] STICK_CENTER = 8'd127;
    localparam logic [16:0] NEUTRAL_R2  = 17'd25;
    localparam logic [7:0] HALF_LEVEL   = 8'd128;
    localparam logic [6:0] MAX_EXITS    = 7'd64;
    localparam logic [7:0] FULL_LEVEL   = 8'd255;

    // load targets
    localparam logic [1:0] TBL_ANIM  = 2'd0;
    localparam logic [1:0] TBL_EXIT  = 2'd1;
    localparam logic [1:0] TBL_STATE = 2'd2;
    localparam logic [1:0] TBL_LIST  = 2'd3;

    // looping codes
    localparam logic [1:0] PROG_WRAP   = 2'd1;
    localparam logic [1:0] PROG_BOUNCE = 2'd2;

    // blend codes
    localparam logic [1:0] BLEND_BINARY = 2'd1;
    localparam logic [1:0] BLEND_LINEAR = 2'd2;

    // stick direction codes
    localparam logic [2:0] DIR_NORTH = 3'd1;
    localparam logic [2:0] DIR_EAST  = 3'd2;
    localparam logic [2:0] DIR_SOUTH = 3'd3;
    localparam logic [2:0] DIR_WEST  = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic wr_en;
        logic ld_sample;
        logic st_sel_j;
        logic prog_upd;
        logic i_inc;
        logic take_exit;
        logic ls_load;
        logic sum_acc;
        logic k_clr;
        logic out_load;
    } clam_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic i_done;
        logic pass;
        logic j_done;
        logic out_free;
        logic k_last;
    } clam_stat_t;

    // lights reversed per reversal row
    function automatic logic [4:0] reverse_row(input logic [2:0] r);
        logic [4:0] v;
        case (r)
            3'd0: v = 5'h00;
            3'd1: v = 5'h18;
            3'd2: v = 5'h04;
            3'd3: v = 5'h1C;
            3'd4: v = 5'h03;
            3'd5: v = 5'h1B;
            3'd6: v = 5'h07;
            default: v = 5'h1F;
        endcase
        return v;
    endfunction

    function automatic logic [4:0] ones16(input logic [15:0] v);
        logic [4:0] n;
        n = '0;
        for (int b = 0; b < 16; b++) n = n + 5'(v[b]);
        return n;
    endfunction

    function automatic logic [2:0] ones7(input logic [6:0] v);
        logic [2:0] n;
        n = '0;
        for (int b = 0; b < 7; b++) n = n + 3'(v[b]);
        return n;
    endfunction

    // stick class: [0] neutral, [1] north, [2] east, [3] south, [4] west
    function automatic logic [4:0] stick_class(input logic [7:0] x, input logic [7:0] y);
        logic signed [8:0] dx, dy;
        logic [7:0] ax, ay;
        logic [16:0] r2;
        logic n;
        logic [4:0] c;
        dx = $signed({1'b0, x}) - $signed({1'b0, STICK_CENTER});
        dy = $signed({1'b0, y}) - $signed({1'b0, STICK_CENTER});
        ax = dx[8] ? 8'(-dx) : dx[7:0];
        ay = dy[8] ? 8'(-dy) : dy[7:0];
        r2 = 17'(ax * ax) + 17'(ay * ay);
        n = (r2 <= NEUTRAL_R2);
        c[0] = n;
        c[1] = !n && !dy[8] && (ax <= ay);
        c[2] = !n && !dx[8] && (ay < ax);
        c[3] = !n && dy[8] && (ax <= ay);
        c[4] = !n && dx[8] && (ay < ax);
        return c;
    endfunction

    function automatic logic stick_in(input logic [2:0] dir, input logic [4:0] c);
        logic r;
        case (dir)
            DIR_NORTH: r = c[1];
            DIR_EAST:  r = c[2];
            DIR_SOUTH: r = c[3];
            DIR_WEST:  r = c[4];
            default:   r = c[0];
        endcase
        return r;
    endfunction

    function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                         input logic [1:0] how, input logic [7:0] f);
        logic [16:0] pa, pb;
        logic [7:0] r;
        pa = 17'(a * (9'd256 - {1'b0, f}));
        pb = 17'(b * f);
        case (how)
            BLEND_BINARY: r = (f >= HALF_LEVEL) ? b : a;
            BLEND_LINEAR: r = pa[15:8] + pb[15:8];
            default:      r = a;
        endcase
        return r;
    endfunction

endpackage

/* src/clam_ctrl.sv */
// sequencing state machine of the led animation machine
module clam_ctrl
    import clam_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       mode,
    output logic       in_stall,
    input  clam_stat_t stat,
    output clam_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_RD_ST, S_RD_AN, S_PROG, S_LIST, S_EXIT, S_TEST,
        S_SUM_RD, S_SUM_ACC, S_C1, S_C2, S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.wr_en     = accept && !mode;
        cmd.ld_sample = accept && mode;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && mode) state_next = S_RD_ST;
            end
            S_RD_ST: state_next = S_RD_AN;
            S_RD_AN: state_next = S_PROG;
            S_PROG:
            begin
                cmd.prog_upd = 1'b1;
                state_next = S_LIST;
            end
            S_LIST: state_next = stat.i_done ? S_C1 : S_EXIT;
            S_EXIT: state_next = S_TEST;
            S_TEST:
            begin
                if (stat.pass)
                begin
                    cmd.take_exit = 1'b1;
                    state_next = S_SUM_RD;
                end
                else
                begin
                    cmd.i_inc = 1'b1;
                    state_next = S_LIST;
                end
            end
            S_SUM_RD:
            begin
                cmd.st_sel_j = 1'b1;
                if (stat.j_done)
                begin
                    cmd.ls_load = 1'b1;
                    state_next = S_C1;
                end
                else
                begin
                    state_next = S_SUM_ACC;
                end
            end
            S_SUM_ACC:
            begin
                cmd.st_sel_j = 1'b1;
                cmd.sum_acc = 1'b1;
                state_next = S_SUM_RD;
            end
            S_C1: state_next = S_C2;
            S_C2:
            begin
                cmd.k_clr = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (stat.k_last) state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/clam_dp.sv */
// tables, machine registers, exit test and color blend of the led animation machine
module clam_dp
    import clam_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  clam_cmd_t   cmd,
    output clam_stat_t  stat,
    input  logic [1:0]  table_select,
    input  logic [5:0]  entry_index,
    input  logic        word_select,
    input  logic [63:0] load_data,
    input  logic [15:0] buttons,
    input  logic [7:0]  joy_x,
    input  logic [7:0]  joy_y,
    input  logic [7:0]  cstick_x,
    input  logic [7:0]  cstick_y,
    input  logic [7:0]  trigger_left,
    input  logic [7:0]  trigger_right,
    input  logic        out_stall,
    output logic        out_valid,
    output logic [2:0]  light_index,
    output logic        lit,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [3:0]  state_now,
    output logic [7:0]  progress,
    output logic        last
);

    // table memories
    logic [47:0] anim_colors [ANIM_DEPTH];
    logic [19:0] anim_modes [ANIM_DEPTH];
    logic [33:0] exit_main [EXIT_DEPTH];
    logic [39:0] exit_limits [EXIT_DEPTH];
    logic [10:0] state_entries [STATE_DEPTH];
    logic [5:0]  exit_list [EXIT_LIST_DEPTH];

    logic [47:0] col_q;
    logic [19:0] mode_q;
    logic [33:0] em_q;
    logic [39:0] el_q;
    logic [10:0] st_q;
    logic [5:0]  list_q;

    // machine registers
    logic [3:0] cur_reg;
    logic [7:0] prog_reg;
    logic       bounce_reg;
    logic [5:0] ls_reg;
    logic [6:0] i_reg;
    logic [6:0] count_reg;
    logic [3:0] j_reg;
    logic [5:0] sum_reg;
    logic [2:0] k_reg;

    // registered controller sample
    logic [15:0] btn_reg;
    logic [7:0]  tl_reg, tr_reg;
    logic [4:0]  js_reg, cs_reg;

    logic [STATE_AW-1:0] st_addr;
    logic [LIST_AW-1:0]  list_addr;

    assign st_addr   = cmd.st_sel_j ? STATE_AW'(j_reg) : STATE_AW'(cur_reg);
    assign list_addr = LIST_AW'(ls_reg + i_reg[5:0]);

    // table writes and registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            case (table_select)
                TBL_ANIM:
                begin
                    if (entry_index < 6'(ANIM_DEPTH))
                    begin
                        if (word_select) anim_modes[ANIM_AW'(entry_index)] <= load_data[19:0];
                        else anim_colors[ANIM_AW'(entry_index)] <= load_data[47:0];
                    end
                end
                TBL_EXIT:
                begin
                    if (word_select) exit_limits[EXIT_AW'(entry_index)] <= load_data[39:0];
                    else exit_main[EXIT_AW'(entry_index)] <= load_data[33:0];
                end
                TBL_STATE:
                begin
                    if (entry_index < 6'(STATE_DEPTH))
                        state_entries[STATE_AW'(entry_index)] <= load_data[10:0];
                end
                default: exit_list[LIST_AW'(entry_index)] <= load_data[5:0];
            endcase
        end
        st_q   <= state_entries[st_addr];
        col_q  <= anim_colors[ANIM_AW'(st_q[3:0])];
        mode_q <= anim_modes[ANIM_AW'(st_q[3:0])];
        list_q <= exit_list[list_addr];
        em_q   <= exit_main[EXIT_AW'(list_q)];
        el_q   <= exit_limits[EXIT_AW'(list_q)];
    end

    // controller sample capture
    always_ff @(posedge clk)
    begin
        if (cmd.ld_sample)
        begin
            btn_reg <= buttons;
            tl_reg  <= trigger_left;
            tr_reg  <= trigger_right;
            js_reg  <= stick_class(joy_x, joy_y);
            cs_reg  <= stick_class(cstick_x, cstick_y);
        end
    end

    // progress advance
    logic [7:0] speed;
    logic [1:0] loop_mode;
    logic [8:0] psum;
    logic [7:0] prog_adv;
    logic       bounce_adv;

    assign speed     = mode_q[9:2];
    assign loop_mode = mode_q[11:10];
    assign psum      = {1'b0, prog_reg} + {1'b0, speed};

    always_comb
    begin
        prog_adv = prog_reg;
        bounce_adv = bounce_reg;
        if (loop_mode == PROG_WRAP)
        begin
            prog_adv = psum[7:0];
        end
        else if (loop_mode == PROG_BOUNCE && bounce_reg)
        begin
            if (prog_reg <= speed)
            begin
                prog_adv = '0;
                bounce_adv = 1'b0;
            end
            else
            begin
                prog_adv = prog_reg - speed;
            end
        end
        else if (psum >= {1'b0, FULL_LEVEL})
        begin
            prog_adv = FULL_LEVEL;
            if (loop_mode == PROG_BOUNCE) bounce_adv = 1'b1;
        end
        else
        begin
            prog_adv = psum[7:0];
        end
    end

    // exit test
    logic [15:0] bmask;
    logic [6:0]  amask;
    logic [6:0]  atest;
    logic [5:0]  hits;
    logic [5:0]  need;

    assign bmask = em_q[15:0];
    assign amask = em_q[22:16];

    always_comb
    begin
        atest[0] = stick_in(em_q[30:28], js_reg);
        atest[1] = stick_in(em_q[33:31], cs_reg);
        atest[2] = tl_reg > el_q[7:0];
        atest[3] = tl_reg < el_q[15:8];
        atest[4] = tr_reg > el_q[23:16];
        atest[5] = tr_reg < el_q[31:24];
        atest[6] = prog_reg >= el_q[39:32];
        hits = 6'(ones16(bmask & btn_reg)) + 6'(ones7(amask & atest));
        need = 6'(ones16(bmask)) + 6'(ones7(amask));
        stat.pass = em_q[23] ? (hits != 6'd0) : (hits >= need);
    end

    assign stat.i_done = (i_reg >= count_reg);
    assign stat.j_done = (j_reg == cur_reg);
    assign stat.k_last = (k_reg == 3'(NUM_LIGHTS - 1));
    assign stat.out_free = !out_valid || !out_stall;

    // machine register updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg    <= '0;
            prog_reg   <= '0;
            bounce_reg <= 1'b0;
            ls_reg     <= '0;
            i_reg      <= '0;
            count_reg  <= '0;
            j_reg      <= '0;
            sum_reg    <= '0;
            k_reg      <= '0;
        end
        else
        begin
            if (cmd.prog_upd)
            begin
                prog_reg   <= prog_adv;
                bounce_reg <= bounce_adv;
                i_reg      <= '0;
                count_reg  <= (st_q[10:4] > MAX_EXITS) ? MAX_EXITS : st_q[10:4];
            end
            if (cmd.i_inc) i_reg <= i_reg + 7'd1;
            if (cmd.take_exit)
            begin
                cur_reg    <= em_q[27:24];
                prog_reg   <= '0;
                bounce_reg <= 1'b0;
                j_reg      <= '0;
                sum_reg    <= '0;
            end
            if (cmd.sum_acc)
            begin
                sum_reg <= sum_reg + st_q[9:4];
                j_reg   <= j_reg + 4'd1;
            end
            if (cmd.ls_load) ls_reg <= sum_reg;
            if (cmd.k_clr) k_reg <= '0;
            else if (cmd.out_load) k_reg <= k_reg + 3'd1;
        end
    end

    // light color for the current light
    logic [4:0] pat;
    logic [4:0] rev;
    logic [7:0] fac;
    logic       on;

    assign pat = mode_q[16:12];
    assign rev = reverse_row(mode_q[19:17]);
    assign on  = pat[k_reg];
    assign fac = rev[k_reg] ? ~prog_reg : prog_reg;

    // output register
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            light_index <= k_reg;
            lit         <= on;
            red         <= on ? blend(col_q[7:0], col_q[31:24], mode_q[1:0], fac) : 8'd0;
            green       <= on ? blend(col_q[15:8], col_q[39:32], mode_q[1:0], fac) : 8'd0;
            blue        <= on ? blend(col_q[23:16], col_q[47:40], mode_q[1:0], fac) : 8'd0;
            state_now   <= cur_reg;
            progress    <= prog_reg;
            last        <= stat.k_last;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* src/controller_led_animation_machine_top.sv */
// A load writes one table entry. A tick advances progress, walks the exit
// list and exit table memories, which sets the tick time, sums the exit
// counts of earlier states on a taken exit and emits one result per light.
// One item at a time: in_stall holds off new items until the tick ends.
// Reset: state, progress, bounce direction and list start clear to zero;
// table contents stay undefined until loaded.
module controller_led_animation_machine_top
    import clam_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [1:0]  table_select,
    input  logic [5:0]  entry_index,
    input  logic        word_select,
    input  logic [63:0] load_data,
    input  logic [15:0] buttons,
    input  logic [7:0]  joy_x,
    input  logic [7:0]  joy_y,
    input  logic [7:0]  cstick_x,
    input  logic [7:0]  cstick_y,
    input  logic [7:0]  trigger_left,
    input  logic [7:0]  trigger_right,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  light_index,
    output logic        lit,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [3:0]  state_now,
    output logic [7:0]  progress,
    output logic        last
);

    clam_cmd_t  cmd;
    clam_stat_t stat;

    // sequencer
    clam_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    clam_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .table_select  (table_select),
        .entry_index   (entry_index),
        .word_select   (word_select),
        .load_data     (load_data),
        .buttons       (buttons),
        .joy_x         (joy_x),
        .joy_y         (joy_y),
        .cstick_x      (cstick_x),
        .cstick_y      (cstick_y),
        .trigger_left  (trigger_left),
        .trigger_right (trigger_right),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .light_index   (light_index),
        .lit           (lit),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .state_now     (state_now),
        .progress      (progress),
        .last          (last)
    );

endmodule

/* src/clam_checker.sv */
// port-level checks of the led animation machine and their binding
`include "controller_led_animation_machine_top_defines.svh"

module clam_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       mode,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] light_index,
    input logic       last
);

    // a waiting result transaction stays offered
    `CLAM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
    // a load transaction leaves the block ready again
    `CLAM_ASSERT_NEXT(a_load_ready, in_valid && !in_stall && !mode, !in_stall, "busy after load")
    // a tick transaction makes the block busy
    `CLAM_ASSERT_NEXT(a_tick_busy, in_valid && !in_stall && mode, in_stall, "ready right after tick")
    // last marks the fifth light only
    `CLAM_ASSERT_NOW(a_last_light, out_valid, last == (light_index == 3'd4), "last flag mismatch")

endmodule

bind controller_led_animation_machine_top clam_checker u_clam_checker (.*);
